@@ hdl/tsp_pkg.sv @@
package tsp_pkg;

  // Fixed header layout: 16-bit type word, then 16-bit length word.
  localparam int HEADER_BYTES = 4;
  localparam int SHIFT_W      = 8 * (HEADER_BYTES - 1);
  localparam int HBC_W        = $clog2(HEADER_BYTES);

  localparam int MAX_TRACKED_FIELDS_DEF = 16;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_ID_MASK      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_FLAG_MASK = CFG_IDX_W'(1);

  localparam logic [15:0] FIELD_ID_MASK_RST      = 16'h7FFF;
  localparam logic [15:0] REQUIRED_FLAG_MASK_RST = 16'h8000;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    EV_HEADER = 2'd0,
    EV_VALUE  = 2'd1,
    EV_END    = 2'd2,
    EV_ERROR  = 2'd3
  } evt_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_HEADER = 2'd1,
    ERR_DUPLICATE  = 2'd2,
    ERR_TABLE_FULL = 2'd3
  } err_code_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] message_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    evt_kind_t   event_kind;
    logic [15:0] fld_id;
    logic        required;
    logic [15:0] value_length;
    logic [15:0] value_offset;
    logic [7:0]  value_byte;
    logic        last_value_byte;
    err_code_t   error_code;
  } evt_t;

  typedef struct packed {
    logic        clear;
    logic        insert;
    logic [15:0] id;
  } tbl_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
  } tbl_stat_t;

endpackage

@@ hdl/tsp_id_table.sv @@
module tsp_id_table
  import tsp_pkg::*;
#(
  parameter int MAX_TRACKED_FIELDS = MAX_TRACKED_FIELDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tbl_cmd_t  cmd,
  output tbl_stat_t stat
);

  localparam int CNT_W = $clog2(MAX_TRACKED_FIELDS + 1);
  localparam int IDX_W = (MAX_TRACKED_FIELDS > 1) ? $clog2(MAX_TRACKED_FIELDS) : 1;

  logic [15:0]      ids_r [MAX_TRACKED_FIELDS];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Parallel compare against every filled entry.
  always_comb begin
    stat.hit = 1'b0;
    for (int i = 0; i < MAX_TRACKED_FIELDS; i++) begin
      if ((CNT_W'(i) < count_r) && (ids_r[i] == cmd.id)) begin
        stat.hit = 1'b1;
      end
    end
    stat.full = (count_r >= CNT_W'(MAX_TRACKED_FIELDS));
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.insert && !stat.full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entries carry no reset; only those below the count are compared.
  always_ff @(posedge clk) begin
    if (cmd.insert && !cmd.clear && !stat.full) begin
      ids_r[count_r[IDX_W-1:0]] <= cmd.id;
    end
  end

endmodule

@@ hdl/tsp_parse.sv @@
module tsp_parse
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  item_t       item,
  input  logic [15:0] field_id_mask,
  input  logic [15:0] required_flag_mask,
  input  tbl_stat_t   tbl_stat,
  output tbl_cmd_t    tbl_cmd,
  output logic        has_result,
  output evt_t        evt
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_VALUE  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  phase_t             phase_r,  phase_nxt;
  logic [SHIFT_W-1:0] shift_r,  shift_nxt;
  logic [HBC_W-1:0]   hbc_r,    hbc_nxt;
  logic [15:0]        off_r,    off_nxt;
  logic [15:0]        total_r,  total_nxt;
  logic [15:0]        remain_r, remain_nxt;

  logic [15:0] off_inc;
  logic [15:0] type_word;
  logic [15:0] vlen;
  logic [15:0] fid;
  logic [15:0] left;
  logic [15:0] remain_dec;
  logic        truncated;
  logic        insert_ok;

  assign off_inc    = off_r + 16'd1;
  assign type_word  = shift_r[SHIFT_W-1 -: 16];
  assign vlen       = {shift_r[7:0], item.data_byte};
  assign fid        = type_word & field_id_mask;
  assign left       = (off_inc <= total_r) ? (total_r - off_inc) : 16'd0;
  assign remain_dec = (remain_r == 16'd0) ? 16'd0 : (remain_r - 16'd1);
  // Fewer than a full header left: offset plus header size past the end.
  assign truncated  = (({1'b0, off_r} + 17'(HEADER_BYTES)) > {1'b0, total_r});

  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    hbc_nxt    = hbc_r;
    off_nxt    = off_r;
    total_nxt  = total_r;
    remain_nxt = remain_r;
    has_result = 1'b0;
    evt        = '0;
    insert_ok  = 1'b0;
    tbl_cmd    = '0;
    tbl_cmd.id = fid;

    if (item.operation == OP_START) begin
      total_nxt     = item.message_length;
      off_nxt       = '0;
      shift_nxt     = '0;
      hbc_nxt       = '0;
      remain_nxt    = '0;
      tbl_cmd.clear = fire;
      phase_nxt     = (item.message_length == 16'd0) ? PH_DONE : PH_HEADER;
    end else begin
      case (phase_r)
        PH_DONE: begin
          has_result       = 1'b1;
          evt.event_kind   = EV_END;
          phase_nxt        = PH_IDLE;
        end
        PH_VALUE: begin
          has_result          = 1'b1;
          evt.event_kind      = EV_VALUE;
          evt.value_byte      = item.data_byte;
          evt.last_value_byte = (remain_r <= 16'd1);
          off_nxt             = off_inc;
          remain_nxt          = remain_dec;
          if (remain_dec == 16'd0) begin
            hbc_nxt   = '0;
            shift_nxt = '0;
            phase_nxt = (off_inc >= total_r) ? PH_DONE : PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (hbc_r == '0 && truncated) begin
            has_result     = 1'b1;
            evt.event_kind = EV_ERROR;
            evt.error_code = ERR_BAD_HEADER;
            phase_nxt      = PH_IDLE;
          end else if (hbc_r != HBC_W'(HEADER_BYTES - 1)) begin
            off_nxt   = off_inc;
            shift_nxt = {shift_r[SHIFT_W-9:0], item.data_byte};
            hbc_nxt   = hbc_r + HBC_W'(1);
          end else begin
            off_nxt    = off_inc;
            has_result = 1'b1;
            if (fid == 16'd0 || vlen > left) begin
              evt.event_kind = EV_ERROR;
              evt.error_code = ERR_BAD_HEADER;
              phase_nxt      = PH_IDLE;
            end else if (tbl_stat.hit) begin
              evt.event_kind = EV_ERROR;
              evt.error_code = ERR_DUPLICATE;
              phase_nxt      = PH_IDLE;
            end else if (tbl_stat.full) begin
              evt.event_kind = EV_ERROR;
              evt.error_code = ERR_TABLE_FULL;
              phase_nxt      = PH_IDLE;
            end else begin
              insert_ok        = 1'b1;
              evt.event_kind   = EV_HEADER;
              evt.fld_id       = fid;
              evt.required     = ((type_word & required_flag_mask) != 16'd0);
              evt.value_length = vlen;
              evt.value_offset = off_inc;
              remain_nxt       = vlen;
              hbc_nxt          = '0;
              shift_nxt        = '0;
              if (vlen == 16'd0) begin
                phase_nxt = (off_inc >= total_r) ? PH_DONE : PH_HEADER;
              end else begin
                phase_nxt = PH_VALUE;
              end
            end
          end
        end
        default: begin
          // Idle: drop the byte.
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    tbl_cmd.insert = fire && insert_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      shift_r  <= '0;
      hbc_r    <= '0;
      off_r    <= '0;
      total_r  <= '0;
      remain_r <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      shift_r  <= shift_nxt;
      hbc_r    <= hbc_nxt;
      off_r    <= off_nxt;
      total_r  <= total_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

@@ hdl/tlv_stream_parser.sv @@
// A result passes from the input register, where the parse step runs on the accepted
// transaction, into the result register that drives out_valid.
// Throughput: one transaction per cycle, parallel id compare included, while the receiver
// keeps up; a result held by out_stall holds back the next result-making transaction.
// Reset (rst_n, synchronous, active low): parser goes idle, result register empties,
// masks return to 0x7FFF / 0x8000; the id store keeps its contents, only its count clears.
module tlv_stream_parser
  import tsp_pkg::*;
#(
  parameter int MAX_TRACKED_FIELDS = MAX_TRACKED_FIELDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [15:0]          in_message_length,
  input  logic [7:0]           in_data_byte,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_kind,
  output logic [15:0]          out_field_id,
  output logic                 out_required,
  output logic [15:0]          out_value_length,
  output logic [15:0]          out_value_offset,
  output logic [7:0]           out_value_byte,
  output logic                 out_last_value_byte,
  output logic [1:0]           out_error_code,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers
  logic [15:0] field_id_mask_r;
  logic [15:0] required_flag_mask_r;

  // Input register
  logic  in_valid_r;
  item_t item_r;

  // Result register
  logic out_valid_r;
  evt_t out_r;

  // Parse step
  logic      fire;
  logic      has_result;
  evt_t      evt;
  tbl_cmd_t  tbl_cmd;
  tbl_stat_t tbl_stat;

  // Configuration is always writable; software must write it only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_id_mask_r      <= FIELD_ID_MASK_RST;
      required_flag_mask_r <= REQUIRED_FLAG_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIELD_ID_MASK:      field_id_mask_r      <= cfg_data;
        REG_REQUIRED_FLAG_MASK: required_flag_mask_r <= cfg_data;
        default: begin
          // Unknown index: drop the write.
        end
      endcase
    end
  end

  // The held transaction advances when it makes no result, or when the result register
  // is empty or being drained this cycle. Transactions without a result never wait.
  assign fire     = in_valid_r && (!has_result || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.operation      <= in_operation;
      item_r.message_length <= in_message_length;
      item_r.data_byte      <= in_data_byte;
    end
  end

  tsp_parse u_parse (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (fire),
    .item               (item_r),
    .field_id_mask      (field_id_mask_r),
    .required_flag_mask (required_flag_mask_r),
    .tbl_stat           (tbl_stat),
    .tbl_cmd            (tbl_cmd),
    .has_result         (has_result),
    .evt                (evt)
  );

  tsp_id_table #(
    .MAX_TRACKED_FIELDS (MAX_TRACKED_FIELDS)
  ) u_id_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tbl_cmd),
    .stat  (tbl_stat)
  );

  // Result register: load a new result, otherwise empty once the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_r <= evt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_r.event_kind;
  assign out_field_id        = out_r.fld_id;
  assign out_required        = out_r.required;
  assign out_value_length    = out_r.value_length;
  assign out_value_offset    = out_r.value_offset;
  assign out_value_byte      = out_r.value_byte;
  assign out_last_value_byte = out_r.last_value_byte;
  assign out_error_code      = out_r.error_code;

  // A new result never overwrites one that the consumer still holds off.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && has_result) |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  // An accepted header always carries a nonzero field id.
  a_header_fid: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && has_result && evt.event_kind == EV_HEADER) |-> (evt.fld_id != 16'd0))
    else $error("header reported with zero field id");

  // The id store is never written past its capacity, and only with a header result.
  a_insert_ok: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_cmd.insert |-> (!tbl_stat.full && !tbl_stat.hit && has_result))
    else $error("id store insert while full or duplicate");

  // Stall only ever holds back a transaction already in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r)
    else $error("input register lost a stalled transaction");

endmodule
